@@ hdl/pidrk4_pkg.sv @@
// Package for the PID-controlled mass-spring RK4 step core.
// Holds the word format, the sequencer op and register codes and the microprogram ROM.
// Depends on nothing; used by pid_mass_spring_rk4_step_core.
package pidrk4_pkg;

   localparam int DataWidth    = 32;
   localparam int FractionBits = 16;
   localparam int ProdWidth    = 2 * DataWidth + 2;
   localparam int PcWidth      = 7;
   localparam int CsrIdxWidth  = 4;

   // ceil(2^34 / 6): quotient of a magnitude below 2^32 is (m * Recip6) >> 34.
   localparam logic [31:0] Recip6      = 32'hAAAA_AAAB;
   localparam int          Recip6Shift = 34;

   localparam logic [31:0] TargetReset = 32'h0001_0000;
   localparam logic [31:0] InvMassReset = 32'h0001_0000;
   localparam logic [31:0] StepReset   = 32'd655;

   typedef enum logic [2:0] {
      CSR_GAIN_PROP   = 3'd0,
      CSR_GAIN_INTEG  = 3'd1,
      CSR_GAIN_DERIV  = 3'd2,
      CSR_TARGET      = 3'd3,
      CSR_INV_MASS    = 3'd4,
      CSR_DAMPING     = 3'd5,
      CSR_SPRING      = 3'd6,
      CSR_TIME_STEP   = 3'd7
   } csr_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_EXEC,
      ST_WB
   } state_type;

   typedef enum logic [2:0] {
      OP_ADD,
      OP_SUB,
      OP_MUL,
      OP_DIV6,
      OP_OUT,
      OP_CHK,
      OP_END
   } op_type;

   typedef enum logic [4:0] {
      R_ZERO, R_KP, R_KI, R_KD, R_TGT, R_IM, R_C, R_K, R_H, R_HH,
      R_X, R_V, R_I, R_LE, R_XS, R_VS, R_E, R_T, R_U, R_F,
      R_KV, R_AX, R_AV, R_BX, R_BV
   } reg_type;

   typedef struct packed {
      op_type  op;
      reg_type dst;
      reg_type sa;
      reg_type sb;
   } instr_type;

   localparam logic [PcWidth-1:0] PcLast = 7'd104;

   function automatic instr_type mk(op_type op, reg_type dst, reg_type sa, reg_type sb);
      instr_type r;
      r = '{op: op, dst: dst, sa: sa, sb: sb};
      return r;
   endfunction

   // PID law at the stage position XS; updates integral and last error.
   function automatic instr_type pid_step(logic [PcWidth-1:0] k);
      instr_type r;
      case (k)
         7'd0:    r = mk(OP_SUB, R_E,  R_TGT, R_XS);
         7'd1:    r = mk(OP_MUL, R_T,  R_E,   R_H);
         7'd2:    r = mk(OP_ADD, R_I,  R_I,   R_T);
         7'd3:    r = mk(OP_MUL, R_T,  R_KP,  R_E);
         7'd4:    r = mk(OP_MUL, R_U,  R_KI,  R_I);
         7'd5:    r = mk(OP_ADD, R_F,  R_T,   R_U);
         7'd6:    r = mk(OP_SUB, R_T,  R_E,   R_LE);
         7'd7:    r = mk(OP_MUL, R_U,  R_KD,  R_T);
         7'd8:    r = mk(OP_ADD, R_F,  R_F,   R_U);
         default: r = mk(OP_ADD, R_LE, R_E,   R_ZERO);
      endcase
      return r;
   endfunction

   // Acceleration (F - c*v - k*x) / m at the stage state.
   function automatic instr_type acc_step(logic [PcWidth-1:0] k);
      instr_type r;
      case (k)
         7'd0:    r = mk(OP_MUL, R_T,  R_C,  R_VS);
         7'd1:    r = mk(OP_SUB, R_U,  R_F,  R_T);
         7'd2:    r = mk(OP_MUL, R_T,  R_K,  R_XS);
         7'd3:    r = mk(OP_SUB, R_U,  R_U,  R_T);
         default: r = mk(OP_MUL, R_KV, R_IM, R_U);
      endcase
      return r;
   endfunction

   // Next stage state from the start state; XS is formed before VS changes.
   function automatic instr_type upd_step(logic [PcWidth-1:0] k, reg_type hsrc);
      instr_type r;
      case (k)
         7'd0:    r = mk(OP_MUL, R_T,  hsrc, R_VS);
         7'd1:    r = mk(OP_ADD, R_XS, R_X,  R_T);
         7'd2:    r = mk(OP_MUL, R_T,  hsrc, R_KV);
         default: r = mk(OP_ADD, R_VS, R_V,  R_T);
      endcase
      return r;
   endfunction

   function automatic instr_type prog(logic [PcWidth-1:0] pc);
      instr_type r;
      if (pc == 7'd0)       r = mk(OP_ADD, R_XS, R_X, R_ZERO);
      else if (pc == 7'd1)  r = mk(OP_ADD, R_VS, R_V, R_ZERO);
      else if (pc <= 7'd11) r = pid_step(pc - 7'd2);
      else if (pc == 7'd12) r = mk(OP_OUT, R_ZERO, R_ZERO, R_ZERO);
      else if (pc == 7'd13) r = mk(OP_CHK, R_ZERO, R_ZERO, R_ZERO);
      // first stage
      else if (pc <= 7'd23) r = pid_step(pc - 7'd14);
      else if (pc <= 7'd28) r = acc_step(pc - 7'd24);
      else if (pc == 7'd29) r = mk(OP_ADD, R_AX, R_VS, R_ZERO);
      else if (pc == 7'd30) r = mk(OP_ADD, R_AV, R_KV, R_ZERO);
      else if (pc <= 7'd34) r = upd_step(pc - 7'd31, R_HH);
      // second stage
      else if (pc <= 7'd44) r = pid_step(pc - 7'd35);
      else if (pc <= 7'd49) r = acc_step(pc - 7'd45);
      else if (pc == 7'd50) r = mk(OP_ADD, R_T,  R_VS, R_VS);
      else if (pc == 7'd51) r = mk(OP_ADD, R_AX, R_AX, R_T);
      else if (pc == 7'd52) r = mk(OP_ADD, R_T,  R_KV, R_KV);
      else if (pc == 7'd53) r = mk(OP_ADD, R_AV, R_AV, R_T);
      else if (pc <= 7'd57) r = upd_step(pc - 7'd54, R_HH);
      // third stage
      else if (pc <= 7'd67) r = pid_step(pc - 7'd58);
      else if (pc <= 7'd72) r = acc_step(pc - 7'd68);
      else if (pc == 7'd73) r = mk(OP_ADD, R_BX, R_VS, R_VS);
      else if (pc == 7'd74) r = mk(OP_ADD, R_BV, R_KV, R_KV);
      else if (pc <= 7'd78) r = upd_step(pc - 7'd75, R_H);
      // fourth stage and weighted combination
      else if (pc <= 7'd88) r = pid_step(pc - 7'd79);
      else if (pc <= 7'd93) r = acc_step(pc - 7'd89);
      else if (pc == 7'd94) r = mk(OP_ADD,  R_BX, R_BX, R_VS);
      else if (pc == 7'd95) r = mk(OP_ADD,  R_BV, R_BV, R_KV);
      else if (pc == 7'd96) r = mk(OP_ADD,  R_AX, R_AX, R_BX);
      else if (pc == 7'd97) r = mk(OP_MUL,  R_T,  R_AX, R_H);
      else if (pc == 7'd98) r = mk(OP_DIV6, R_T,  R_T,  R_ZERO);
      else if (pc == 7'd99) r = mk(OP_ADD,  R_X,  R_X,  R_T);
      else if (pc == 7'd100) r = mk(OP_ADD,  R_AV, R_AV, R_BV);
      else if (pc == 7'd101) r = mk(OP_MUL,  R_T,  R_AV, R_H);
      else if (pc == 7'd102) r = mk(OP_DIV6, R_T,  R_T,  R_ZERO);
      else if (pc == 7'd103) r = mk(OP_ADD,  R_V,  R_V,  R_T);
      else                  r = mk(OP_END,  R_ZERO, R_ZERO, R_ZERO);
      return r;
   endfunction

   // Clamp a wide signed value to the signed data word.
   function automatic logic [DataWidth-1:0] sat_word(logic [ProdWidth-1:0] v);
      logic [ProdWidth-DataWidth:0] top;
      top = v[ProdWidth-1:DataWidth-1];
      if (top == '0 || top == '1) return v[DataWidth-1:0];
      else if (v[ProdWidth-1])    return {1'b1, {(DataWidth-1){1'b0}}};
      else                        return {1'b0, {(DataWidth-1){1'b1}}};
   endfunction

endpackage

@@ hdl/pid_mass_spring_rk4_step_core.sv @@
// Top level of the PID-controlled mass-spring-damper RK4 step core.
// Depends on pidrk4_pkg for the microprogram, op codes and saturation helper.
//
// Usage: each request on req_* is one simulation tick. req_tdata bit 0 is
// restart, which zeroes position, velocity and integral and loads the last
// error with the setpoint before sampling; bit 1 is advance, which runs one
// RK4 step after the sample. Every request gives exactly one response on
// rsp_* with the position and velocity before the step and the PID force at
// that state. The user is to write coefficients on the csr_* port while the
// core is idle; the core does not enforce it. Indexes past the last
// register are ignored. One request walks a 105-entry microprogram on a
// single shared saturating add/subtract/multiply unit. Every arithmetic
// instruction operates in ST_EXEC, then saturates and writes back in ST_WB.
// A sample-only request goes back to idle at the check instruction after
// its response is registered; a request with advance runs to the end. The
// core accepts no request while the microprogram runs.
// Reset returns all coefficients and state to their documented defaults.
// If the receiver stalls, the response register holds its value and the
// sequencer waits at its output instruction until the old response is taken.
module pid_mass_spring_rk4_step_core (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // [0] restart, [1] advance, [7:2] zero
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [95:0] rsp_tdata,   // [31:0] sample_position,
                                    // [63:32] sample_velocity, [95:64] sample_force
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [3:0]  csr_index,
   input  logic [31:0] csr_data
);

   localparam int DW = pidrk4_pkg::DataWidth;
   localparam int PW = pidrk4_pkg::ProdWidth;

   // Coefficient registers.
   logic [DW-1:0] kp_ff, kp_in, ki_ff, ki_in, kd_ff, kd_in, tgt_ff, tgt_in;
   logic [DW-1:0] im_ff, im_in, c_ff, c_in, k_ff, k_in, h_ff, h_in;
   // Plant and controller state.
   logic [DW-1:0] x_ff, x_in, v_ff, v_in, i_ff, i_in, le_ff, le_in;
   // Scratch registers of the microprogram.
   logic [DW-1:0] xs_ff, xs_in, vs_ff, vs_in, e_ff, e_in, t_ff, t_in;
   logic [DW-1:0] u_ff, u_in, f_ff, f_in, kv_ff, kv_in;
   logic [DW-1:0] ax_ff, ax_in, av_ff, av_in, bx_ff, bx_in, bv_ff, bv_in;

   pidrk4_pkg::state_type state_ff, state_in;
   logic [pidrk4_pkg::PcWidth-1:0] pc_ff, pc_in;
   logic adv_ff, adv_in;
   logic [PW-1:0] raw_ff, raw_in;
   logic neg_ff, neg_in;
   logic rsp_valid_ff, rsp_valid_in;
   logic [95:0] rsp_data_ff, rsp_data_in;

   pidrk4_pkg::instr_type instr;
   logic [DW-1:0] opa, opb, amag, result;
   logic signed [DW:0] mul_a, mul_b;
   logic signed [PW-1:0] mul_p;
   logic [PW-1:0] shifted;
   logic [DW-1:0] quot;

   function automatic logic [DW-1:0] pick(pidrk4_pkg::reg_type r,
      logic [DW-1:0] kp, logic [DW-1:0] ki, logic [DW-1:0] kd, logic [DW-1:0] tgt,
      logic [DW-1:0] im, logic [DW-1:0] c, logic [DW-1:0] k, logic [DW-1:0] h,
      logic [DW-1:0] x, logic [DW-1:0] v, logic [DW-1:0] i, logic [DW-1:0] le,
      logic [DW-1:0] xs, logic [DW-1:0] vs, logic [DW-1:0] e, logic [DW-1:0] t,
      logic [DW-1:0] u, logic [DW-1:0] f, logic [DW-1:0] kv, logic [DW-1:0] ax,
      logic [DW-1:0] av, logic [DW-1:0] bx, logic [DW-1:0] bv);
      logic [DW-1:0] r_val;
      unique case (r)
         pidrk4_pkg::R_KP:  r_val = kp;
         pidrk4_pkg::R_KI:  r_val = ki;
         pidrk4_pkg::R_KD:  r_val = kd;
         pidrk4_pkg::R_TGT: r_val = tgt;
         pidrk4_pkg::R_IM:  r_val = im;
         pidrk4_pkg::R_C:   r_val = c;
         pidrk4_pkg::R_K:   r_val = k;
         pidrk4_pkg::R_H:   r_val = h;
         pidrk4_pkg::R_HH:  r_val = {1'b0, h[DW-1:1]};
         pidrk4_pkg::R_X:   r_val = x;
         pidrk4_pkg::R_V:   r_val = v;
         pidrk4_pkg::R_I:   r_val = i;
         pidrk4_pkg::R_LE:  r_val = le;
         pidrk4_pkg::R_XS:  r_val = xs;
         pidrk4_pkg::R_VS:  r_val = vs;
         pidrk4_pkg::R_E:   r_val = e;
         pidrk4_pkg::R_T:   r_val = t;
         pidrk4_pkg::R_U:   r_val = u;
         pidrk4_pkg::R_F:   r_val = f;
         pidrk4_pkg::R_KV:  r_val = kv;
         pidrk4_pkg::R_AX:  r_val = ax;
         pidrk4_pkg::R_AV:  r_val = av;
         pidrk4_pkg::R_BX:  r_val = bx;
         pidrk4_pkg::R_BV:  r_val = bv;
         default:           r_val = '0;
      endcase
      return r_val;
   endfunction

   assign instr = pidrk4_pkg::prog(pc_ff);
   assign opa = pick(instr.sa, kp_ff, ki_ff, kd_ff, tgt_ff, im_ff, c_ff, k_ff, h_ff,
                     x_ff, v_ff, i_ff, le_ff, xs_ff, vs_ff, e_ff, t_ff, u_ff, f_ff,
                     kv_ff, ax_ff, av_ff, bx_ff, bv_ff);
   assign opb = pick(instr.sb, kp_ff, ki_ff, kd_ff, tgt_ff, im_ff, c_ff, k_ff, h_ff,
                     x_ff, v_ff, i_ff, le_ff, xs_ff, vs_ff, e_ff, t_ff, u_ff, f_ff,
                     kv_ff, ax_ff, av_ff, bx_ff, bv_ff);

   // The one shared multiplier: signed products, or the magnitude times the
   // reciprocal of six for the final truncating division.
   assign amag = opa[DW-1] ? (~opa + 1'b1) : opa;
   always_comb begin
      if (instr.op == pidrk4_pkg::OP_DIV6) begin
         mul_a = {1'b0, amag};
         mul_b = {1'b0, pidrk4_pkg::Recip6};
      end else begin
         mul_a = {opa[DW-1], opa};
         mul_b = {opb[DW-1], opb};
      end
   end
   assign mul_p = mul_a * mul_b;

   // Write-back value; an arithmetic shift floors the product.
   assign shifted = PW'($signed(raw_ff) >>> pidrk4_pkg::FractionBits);
   assign quot = DW'(raw_ff[PW-3:pidrk4_pkg::Recip6Shift]);
   always_comb begin
      case (instr.op)
         pidrk4_pkg::OP_MUL:  result = pidrk4_pkg::sat_word(shifted);
         pidrk4_pkg::OP_DIV6: result = neg_ff ? (~quot + 1'b1) : quot;
         default:             result = pidrk4_pkg::sat_word(raw_ff);
      endcase
   end

   assign csr_ready  = 1'b1;
   assign req_tready = (state_ff == pidrk4_pkg::ST_IDLE);
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   always_comb begin
      kp_in = kp_ff;  ki_in = ki_ff;  kd_in = kd_ff;  tgt_in = tgt_ff;
      im_in = im_ff;  c_in = c_ff;    k_in = k_ff;    h_in = h_ff;
      x_in = x_ff;    v_in = v_ff;    i_in = i_ff;    le_in = le_ff;
      xs_in = xs_ff;  vs_in = vs_ff;  e_in = e_ff;    t_in = t_ff;
      u_in = u_ff;    f_in = f_ff;    kv_in = kv_ff;
      ax_in = ax_ff;  av_in = av_ff;  bx_in = bx_ff;  bv_in = bv_ff;
      state_in = state_ff;
      pc_in = pc_ff;
      adv_in = adv_ff;
      raw_in = raw_ff;
      neg_in = neg_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_data_in = rsp_data_ff;

      if (csr_valid && csr_index[3] == 1'b0) begin
         unique case (pidrk4_pkg::csr_type'(csr_index[2:0]))
            pidrk4_pkg::CSR_GAIN_PROP:  kp_in  = csr_data;
            pidrk4_pkg::CSR_GAIN_INTEG: ki_in  = csr_data;
            pidrk4_pkg::CSR_GAIN_DERIV: kd_in  = csr_data;
            pidrk4_pkg::CSR_TARGET:     tgt_in = csr_data;
            pidrk4_pkg::CSR_INV_MASS:   im_in  = {1'b0, csr_data[DW-2:0]};
            pidrk4_pkg::CSR_DAMPING:    c_in   = {1'b0, csr_data[DW-2:0]};
            pidrk4_pkg::CSR_SPRING:     k_in   = {1'b0, csr_data[DW-2:0]};
            pidrk4_pkg::CSR_TIME_STEP:  h_in   = {1'b0, csr_data[DW-2:0]};
            default: ;
         endcase
      end

      unique case (state_ff)
         pidrk4_pkg::ST_IDLE: begin
            if (req_tvalid) begin
               adv_in = req_tdata[1];
               pc_in = '0;
               state_in = pidrk4_pkg::ST_EXEC;
               if (req_tdata[0]) begin
                  x_in = '0;
                  v_in = '0;
                  i_in = '0;
                  le_in = tgt_ff;
               end
            end
         end
         pidrk4_pkg::ST_EXEC: begin
            unique case (instr.op)
               pidrk4_pkg::OP_OUT: begin
                  if (!(rsp_valid_ff && !rsp_tready)) begin
                     rsp_valid_in = 1'b1;
                     rsp_data_in = {f_ff, v_ff, x_ff};
                     pc_in = pc_ff + 1'b1;
                  end
               end
               pidrk4_pkg::OP_CHK: begin
                  if (adv_ff) pc_in = pc_ff + 1'b1;
                  else        state_in = pidrk4_pkg::ST_IDLE;
               end
               pidrk4_pkg::OP_END: state_in = pidrk4_pkg::ST_IDLE;
               pidrk4_pkg::OP_ADD: begin
                  raw_in = PW'($signed(opa)) + PW'($signed(opb));
                  state_in = pidrk4_pkg::ST_WB;
               end
               pidrk4_pkg::OP_SUB: begin
                  raw_in = PW'($signed(opa)) - PW'($signed(opb));
                  state_in = pidrk4_pkg::ST_WB;
               end
               default: begin
                  raw_in = mul_p;
                  neg_in = opa[DW-1];
                  state_in = pidrk4_pkg::ST_WB;
               end
            endcase
         end
         pidrk4_pkg::ST_WB: begin
            unique case (instr.dst)
               pidrk4_pkg::R_X:  x_in  = result;
               pidrk4_pkg::R_V:  v_in  = result;
               pidrk4_pkg::R_I:  i_in  = result;
               pidrk4_pkg::R_LE: le_in = result;
               pidrk4_pkg::R_XS: xs_in = result;
               pidrk4_pkg::R_VS: vs_in = result;
               pidrk4_pkg::R_E:  e_in  = result;
               pidrk4_pkg::R_T:  t_in  = result;
               pidrk4_pkg::R_U:  u_in  = result;
               pidrk4_pkg::R_F:  f_in  = result;
               pidrk4_pkg::R_KV: kv_in = result;
               pidrk4_pkg::R_AX: ax_in = result;
               pidrk4_pkg::R_AV: av_in = result;
               pidrk4_pkg::R_BX: bx_in = result;
               pidrk4_pkg::R_BV: bv_in = result;
               default: ;
            endcase
            pc_in = pc_ff + 1'b1;
            state_in = pidrk4_pkg::ST_EXEC;
         end
         default: state_in = pidrk4_pkg::ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= pidrk4_pkg::ST_IDLE;
         pc_ff <= '0;
         adv_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
         kp_ff <= '0;
         ki_ff <= '0;
         kd_ff <= '0;
         tgt_ff <= pidrk4_pkg::TargetReset;
         im_ff <= pidrk4_pkg::InvMassReset;
         c_ff <= '0;
         k_ff <= '0;
         h_ff <= pidrk4_pkg::StepReset;
         x_ff <= '0;
         v_ff <= '0;
         i_ff <= '0;
         le_ff <= pidrk4_pkg::TargetReset;
      end else begin
         state_ff <= state_in;
         pc_ff <= pc_in;
         adv_ff <= adv_in;
         rsp_valid_ff <= rsp_valid_in;
         kp_ff <= kp_in;
         ki_ff <= ki_in;
         kd_ff <= kd_in;
         tgt_ff <= tgt_in;
         im_ff <= im_in;
         c_ff <= c_in;
         k_ff <= k_in;
         h_ff <= h_in;
         x_ff <= x_in;
         v_ff <= v_in;
         i_ff <= i_in;
         le_ff <= le_in;
      end
   end

   always_ff @(posedge clock) begin
      xs_ff <= xs_in;
      vs_ff <= vs_in;
      e_ff <= e_in;
      t_ff <= t_in;
      u_ff <= u_in;
      f_ff <= f_in;
      kv_ff <= kv_in;
      ax_ff <= ax_in;
      av_ff <= av_in;
      bx_ff <= bx_in;
      bv_ff <= bv_in;
      raw_ff <= raw_in;
      neg_ff <= neg_in;
      rsp_data_ff <= rsp_data_in;
   end

   // An accepted request always starts the microprogram from its first entry.
   a_start: assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready) |=> (state_ff == pidrk4_pkg::ST_EXEC && pc_ff == '0))
      else $error("request did not start the microprogram at entry zero");

   // A write-back always returns to the next instruction.
   a_wb: assert property (@(posedge clock) disable iff (reset)
      (state_ff == pidrk4_pkg::ST_WB) |=>
         (state_ff == pidrk4_pkg::ST_EXEC && pc_ff == $past(pc_ff) + 1'b1))
      else $error("write-back did not advance the sequencer");

   // The sequencer never runs past the end of the program.
   a_pc: assert property (@(posedge clock) disable iff (reset)
      (state_ff != pidrk4_pkg::ST_IDLE) |-> (pc_ff <= pidrk4_pkg::PcLast))
      else $error("program counter out of range");

endmodule

@@ test/pid_mass_spring_rk4_step_core_test.sv @@
// Self-checking testbench for pid_mass_spring_rk4_step_core: directed ticks, register
// extremes and long random tick streams with random stalls on both streams.
// Depends on pidrk4_pkg and the core; it carries its own fixed-point plant model.
module pid_mass_spring_rk4_step_core_test;

   localparam int  IdleLimit  = 5000;  // cycles without any handshake before giving up
   localparam int  SettleWait = 260;   // longer than one advancing request
   localparam int  RegCount   = 8;
   localparam longint WordMax = 64'sd2147483647;
   localparam longint WordMin = -64'sd2147483648;
   localparam longint One     = 64'sd65536;

   typedef struct {
      logic [31:0] position;
      logic [31:0] velocity;
      logic [31:0] force_out;
   } sample_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [7:0]  req_tdata = '0;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [95:0] rsp_tdata;
   logic        csr_valid = 1'b0;
   logic        csr_ready;
   logic [3:0]  csr_index = '0;
   logic [31:0] csr_data = '0;

   // Mirror of the coefficient registers and of the plant and controller state.
   longint kp, ki, kd, target, inv_mass, damping, spring, step_h;
   longint pos, vel, integral, last_err;

   sample_type expected_samples[$];
   int  fail_count = 0;
   int  idle_cycles = 0;
   bit  steady_send = 1'b0;   // disables sender gaps
   bit  steady_take = 1'b0;   // disables receiver stalls

   always #6 clock = ~clock;

   pid_mass_spring_rk4_step_core DUT (.*);

   // ---------------- fixed-point plant model ----------------
   function automatic longint clamp_word(longint a);
      if (a > WordMax) return WordMax;
      if (a < WordMin) return WordMin;
      return a;
   endfunction

   function automatic longint qadd(longint a, longint b);
      return clamp_word(a + b);
   endfunction

   function automatic longint qsub(longint a, longint b);
      return clamp_word(a - b);
   endfunction

   // Operands are within the word range, so the exact product fits in 64 bits and the
   // arithmetic shift floors it toward minus infinity.
   function automatic longint qmul(longint a, longint b);
      longint p;
      p = a * b;
      return clamp_word(p >>> pidrk4_pkg::FractionBits);
   endfunction

   // One PID evaluation; it updates the integral and the last error.
   function automatic longint pid_force(longint x);
      longint e, f;
      e = qsub(target, x);
      integral = qadd(integral, qmul(e, step_h));
      f = qadd(qmul(kp, e), qmul(ki, integral));
      f = qadd(f, qmul(kd, qsub(e, last_err)));
      last_err = e;
      return f;
   endfunction

   function automatic longint accel(longint x, longint v, longint f);
      return qmul(inv_mass, qsub(qsub(f, qmul(damping, v)), qmul(spring, x)));
   endfunction

   // Classic RK4 step; every stage runs the PID law again, as the core does.
   function automatic void rk4_step();
      longint x0, v0, half_h, x, v, sx, sv;
      longint kx[4], kv[4];
      x0 = pos;
      v0 = vel;
      half_h = step_h / 2;
      x = x0;
      v = v0;
      for (int s = 0; s < 4; s++) begin
         kx[s] = v;
         kv[s] = accel(x, v, pid_force(x));
         if (s < 2) begin
            x = qadd(x0, qmul(half_h, kx[s]));
            v = qadd(v0, qmul(half_h, kv[s]));
         end else if (s == 2) begin
            x = qadd(x0, qmul(step_h, kx[s]));
            v = qadd(v0, qmul(step_h, kv[s]));
         end
      end
      sx = qadd(qadd(kx[0], qadd(kx[1], kx[1])), qadd(qadd(kx[2], kx[2]), kx[3]));
      sv = qadd(qadd(kv[0], qadd(kv[1], kv[1])), qadd(qadd(kv[2], kv[2]), kv[3]));
      pos = qadd(x0, qmul(sx, step_h) / 6);
      vel = qadd(v0, qmul(sv, step_h) / 6);
   endfunction

   // Works out the response of one tick and advances the mirrored state.
   function automatic sample_type predict_tick(bit restart, bit advance);
      sample_type r;
      longint f;
      if (restart) begin
         pos = 0;
         vel = 0;
         integral = 0;
         last_err = target;
      end
      r.position = pos[31:0];
      r.velocity = vel[31:0];
      f = pid_force(pos);
      r.force_out = f[31:0];
      if (advance) rk4_step();
      return r;
   endfunction

   // ---------------- receiver, checker, watchdog ----------------
   always @(posedge clock) begin
      if (steady_take) rsp_tready <= 1'b1;
      else rsp_tready <= ($urandom_range(99) >= 35);
   end

   always @(posedge clock) begin
      sample_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (expected_samples.size() == 0) begin
            $display("%0t: response with none expected: got %h", $time, rsp_tdata);
            fail_count++;
         end else begin
            want = expected_samples.pop_front();
            if (rsp_tdata[31:0] !== want.position) begin
               $display("%0t: position expected %h actual %h", $time, want.position,
                        rsp_tdata[31:0]);
               fail_count++;
            end
            if (rsp_tdata[63:32] !== want.velocity) begin
               $display("%0t: velocity expected %h actual %h", $time, want.velocity,
                        rsp_tdata[63:32]);
               fail_count++;
            end
            if (rsp_tdata[95:64] !== want.force_out) begin
               $display("%0t: force expected %h actual %h", $time, want.force_out,
                        rsp_tdata[95:64]);
               fail_count++;
            end
         end
      end
   end

   always @(posedge clock) begin
      if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) ||
          (csr_valid && csr_ready)) begin
         idle_cycles <= 0;
      end else begin
         idle_cycles <= idle_cycles + 1;
         if (idle_cycles >= IdleLimit) begin
            $display("CHECK FAILED");
            $finish;
         end
      end
   end

   // ---------------- drivers ----------------
   // Sends one tick request; valid stays high afterwards so that back-to-back
   // requests never lower and raise it in the same step.
   task automatic send_tick(bit restart, bit advance);
      int gap;
      gap = 0;
      if (!steady_send && $urandom_range(99) < 35) gap = $urandom_range(1, 4);
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata <= {6'b0, advance, restart};
      do @(posedge clock); while (!req_tready);
      expected_samples.push_back(predict_tick(restart, advance));
   endtask

   // Lowers valid and waits until every response is in and the core has settled.
   task automatic drain();
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (expected_samples.size() != 0) @(posedge clock);
      repeat (SettleWait) @(posedge clock);
   endtask

   task automatic write_reg(logic [3:0] idx, logic [31:0] val);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data <= val;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      @(posedge clock);
      if (idx < RegCount) begin
         case (pidrk4_pkg::csr_type'(idx[2:0]))
            pidrk4_pkg::CSR_GAIN_PROP:  kp = longint'($signed(val));
            pidrk4_pkg::CSR_GAIN_INTEG: ki = longint'($signed(val));
            pidrk4_pkg::CSR_GAIN_DERIV: kd = longint'($signed(val));
            pidrk4_pkg::CSR_TARGET:     target = longint'($signed(val));
            pidrk4_pkg::CSR_INV_MASS:   inv_mass = longint'(val[30:0]);
            pidrk4_pkg::CSR_DAMPING:    damping = longint'(val[30:0]);
            pidrk4_pkg::CSR_SPRING:     spring = longint'(val[30:0]);
            pidrk4_pkg::CSR_TIME_STEP:  step_h = longint'(val[30:0]);
         endcase
      end
   endtask

   task automatic write_all(longint p, longint i, longint d, longint t,
                            longint m, longint c, longint k, longint h);
      write_reg({1'b0, pidrk4_pkg::CSR_GAIN_PROP},  p[31:0]);
      write_reg({1'b0, pidrk4_pkg::CSR_GAIN_INTEG}, i[31:0]);
      write_reg({1'b0, pidrk4_pkg::CSR_GAIN_DERIV}, d[31:0]);
      write_reg({1'b0, pidrk4_pkg::CSR_TARGET},     t[31:0]);
      write_reg({1'b0, pidrk4_pkg::CSR_INV_MASS},   m[31:0]);
      write_reg({1'b0, pidrk4_pkg::CSR_DAMPING},    c[31:0]);
      write_reg({1'b0, pidrk4_pkg::CSR_SPRING},     k[31:0]);
      write_reg({1'b0, pidrk4_pkg::CSR_TIME_STEP},  h[31:0]);
   endtask

   // Mostly plausible coefficients, sometimes any word, sometimes an extreme.
   function automatic longint pick_coef(longint span);
      int sel;
      sel = $urandom_range(99);
      if (sel < 70) return longint'($urandom_range(0, 32'(span)));
      if (sel < 85) return longint'($signed($urandom()));
      if (sel < 93) return WordMax;
      return WordMin;
   endfunction

   // ---------------- tests ----------------
   // Every tick kind from the reset defaults, with the sender and receiver steady.
   task automatic test_reset_defaults();
      steady_send = 1'b1;
      steady_take = 1'b1;
      send_tick(1'b0, 1'b0);
      send_tick(1'b0, 1'b1);
      send_tick(1'b0, 1'b1);
      send_tick(1'b1, 1'b0);
      send_tick(1'b1, 1'b1);
      send_tick(1'b0, 1'b1);
      drain();
      steady_send = 1'b0;
      steady_take = 1'b0;
   endtask

   // Coefficients at their extremes drive every saturation path, a unit time step
   // makes the half step zero, and writes past the last index must be ignored.
   task automatic test_register_extremes();
      write_all(WordMax, WordMax, WordMax, WordMax, WordMax, WordMax, WordMax, WordMax);
      send_tick(1'b1, 1'b1);
      send_tick(1'b0, 1'b1);
      send_tick(1'b0, 1'b1);
      drain();
      write_all(WordMin, WordMin, WordMin, WordMin, 0, 0, 0, 1);
      send_tick(1'b1, 1'b1);
      send_tick(1'b0, 1'b1);
      send_tick(1'b0, 1'b0);
      drain();
      write_all(2 * One, One / 2, 4 * One, WordMin, WordMax, One, One, WordMax);
      send_tick(1'b1, 1'b1);
      send_tick(1'b0, 1'b1);
      send_tick(1'b1, 1'b0);
      drain();
      write_reg(4'd8, 32'hFFFF_FFFF);
      write_reg(4'd15, 32'h0000_0000);
      write_all(3 * One, One / 4, One / 8, One, One, One / 2, 2 * One, 655);
      for (int n = 0; n < 6; n++) send_tick(1'b0, 1'b1);
      drain();
   endtask

   // Random coefficient sets, each followed by a burst of ticks. One burst runs with
   // no idling at all, and one burst pauses half way until every response is in.
   task automatic test_random_ticks();
      for (int phase = 0; phase < 10; phase++) begin
         if (phase % 4 == 3) begin
            for (int r = 0; r < RegCount; r++) write_reg(r[3:0], $urandom());
         end else begin
            write_all(pick_coef(8 * One), pick_coef(2 * One), pick_coef(8 * One),
                      pick_coef(4 * One), longint'($urandom_range(1, 32'(4 * One))),
                      pick_coef(2 * One), pick_coef(4 * One),
                      longint'($urandom_range(1, 8192)));
         end
         steady_send = (phase == 2);
         steady_take = (phase == 2);
         send_tick(1'b1, 1'b1);
         for (int n = 0; n < 84; n++) begin
            send_tick($urandom_range(99) < 8, $urandom_range(99) < 80);
            if (phase == 5 && n == 40) drain();
         end
         drain();
      end
      steady_send = 1'b0;
      steady_take = 1'b0;
   endtask

   initial begin
      kp = 0;
      ki = 0;
      kd = 0;
      target = One;
      inv_mass = One;
      damping = 0;
      spring = 0;
      step_h = 655;
      pos = 0;
      vel = 0;
      integral = 0;
      last_err = One;
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_reset_defaults();
      test_register_extremes();
      test_random_ticks();
      drain();
      if (fail_count == 0) $display("CHECK OK");
      else $display("CHECK FAILED");
      $finish;
   end
endmodule
